/* hw/rtl/ttod_pkg.sv */
// Shared types and constants of the time-of-day and deadline block.
package ttod_pkg;

	// Field widths
	localparam int unsigned STEP_W  = 20;
	localparam int unsigned US_W    = 32;
	localparam int unsigned DELAY_W = 22;
	localparam int unsigned DAY_W   = 32;
	localparam int unsigned HOUR_W  = 5;
	localparam int unsigned MIN_W   = 6;
	localparam int unsigned SEC_W   = 6;

	// Time constants
	localparam logic [STEP_W:0]   US_PER_SEC = 21'd1000000;
	localparam logic [STEP_W-1:0] STEP_MAX   = 20'd1000000;
	localparam logic [STEP_W-1:0] STEP_RESET = 20'd1000;
	localparam logic [US_W-1:0]   US_PER_MS  = 32'd1000;
	localparam logic [SEC_W-1:0]  SEC_LAST   = 6'd59;
	localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
	localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
	localparam int unsigned       SIGN_BIT   = 31;

	// Request codes
	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_ARM   = 2'd1,
		REQ_CHECK = 2'd2
	} req_code_t;

	// Time of day as seen after the current update
	typedef struct packed {
		logic [DAY_W-1:0]  days;
		logic [HOUR_W-1:0] hours;
		logic [MIN_W-1:0]  mins;
		logic [SEC_W-1:0]  secs;
	} tod_t;

endpackage

/* hw/rtl/ttod_req_if.sv */
// Request channel: valid/ready handshake with the request fields.
interface ttod_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [ttod_pkg::DELAY_W-1:0]  delay_ms;
	logic [ttod_pkg::US_W-1:0]     deadline_in;

	modport source (output valid, req_type, delay_ms, deadline_in, input ready);
	modport sink   (input valid, req_type, delay_ms, deadline_in, output ready);
endinterface

/* hw/rtl/ttod_rsp_if.sv */
// Result channel: valid/ready handshake with the time and deadline fields.
interface ttod_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ttod_pkg::US_W-1:0]    now_us;
	logic [ttod_pkg::DAY_W-1:0]   day_count;
	logic [ttod_pkg::HOUR_W-1:0]  hour_count;
	logic [ttod_pkg::MIN_W-1:0]   minute_count;
	logic [ttod_pkg::SEC_W-1:0]   second_count;
	logic [ttod_pkg::US_W-1:0]    deadline_out;
	logic                         expired;

	modport source (output valid, now_us, day_count, hour_count, minute_count,
		second_count, deadline_out, expired, input ready);
	modport sink   (input valid, now_us, day_count, hour_count, minute_count,
		second_count, deadline_out, expired, output ready);
endinterface

/* hw/rtl/ttod_tod_cascade.sv */
// Seconds, minutes, hours and days counters advanced one second at a time.
module ttod_tod_cascade (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	output ttod_pkg::tod_t tod
);

	ttod_pkg::tod_t tod_q;
	ttod_pkg::tod_t tod_d;
	logic           sec_wrap;
	logic           min_wrap;
	logic           hour_wrap;

	// Carry chain of the cascade
	always_comb begin
		sec_wrap  = (tod_q.secs == ttod_pkg::SEC_LAST);
		min_wrap  = sec_wrap && (tod_q.mins == ttod_pkg::MIN_LAST);
		hour_wrap = min_wrap && (tod_q.hours == ttod_pkg::HOUR_LAST);
		tod_d     = tod_q;
		if (advance) begin
			tod_d.secs = sec_wrap ? '0 : tod_q.secs + 1'b1;
			if (sec_wrap) begin
				tod_d.mins = min_wrap ? '0 : tod_q.mins + 1'b1;
			end
			if (min_wrap) begin
				tod_d.hours = hour_wrap ? '0 : tod_q.hours + 1'b1;
			end
			if (hour_wrap) begin
				tod_d.days = tod_q.days + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tod_q <= '0;
		end else begin
			tod_q <= tod_d;
		end
	end

	// Value after this cycle's update
	assign tod = tod_d;

endmodule

/* hw/rtl/tick_time_of_day_deadline.sv */
// An accepted item is held in the input stage, then registered in the result register.
// Throughput: one item per cycle while the result is taken; input stage, then state update and result register.
// The ready of the request side drops only while both stages hold an item and the result waits.
// Reset clears the microsecond count, the sub-second remainder and the time of day,
// sets the step to 1000 us, and empties both stages.
module tick_time_of_day_deadline (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ttod_pkg::STEP_W-1:0]  cfg_wdata,
	ttod_req_if.sink                     req,
	ttod_rsp_if.source                   rsp
);

	// Step register with saturation
	logic [ttod_pkg::STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ttod_pkg::STEP_RESET;
		end else if (cfg_we) begin
			step_q <= (cfg_wdata > ttod_pkg::STEP_MAX) ? ttod_pkg::STEP_MAX : cfg_wdata;
		end
	end

	// Handshake
	logic req_valid_s1;
	logic rsp_valid_s2;
	logic advance;
	logic accept;

	assign advance   = req_valid_s1 && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	// Input stage; the arm product does not depend on state, so it is formed here
	ttod_pkg::req_code_t          req_type_s1;
	logic [ttod_pkg::US_W-1:0]    delay_us_s1;
	logic [ttod_pkg::US_W-1:0]    deadline_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (accept) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= ttod_pkg::req_code_t'(req.req_type);
			delay_us_s1 <= ttod_pkg::US_W'({{(ttod_pkg::US_W - ttod_pkg::DELAY_W){1'b0}},
				req.delay_ms} * ttod_pkg::US_PER_MS);
			deadline_s1 <= req.deadline_in;
		end
	end

	// Microsecond and sub-second counters
	logic [ttod_pkg::US_W-1:0]   micro_q;
	logic [ttod_pkg::STEP_W-1:0] sub_q;
	logic [ttod_pkg::STEP_W:0]   sub_sum;
	logic                        sec_roll;
	logic                        do_tick;
	logic [ttod_pkg::US_W-1:0]   micro_d;
	logic [ttod_pkg::STEP_W-1:0] sub_d;

	assign do_tick  = advance && (req_type_s1 == ttod_pkg::REQ_TICK);
	assign sub_sum  = {1'b0, sub_q} + {1'b0, step_q};
	assign sec_roll = (sub_sum >= ttod_pkg::US_PER_SEC);

	always_comb begin
		micro_d = micro_q;
		sub_d   = sub_q;
		if (do_tick) begin
			micro_d = micro_q + {{(ttod_pkg::US_W - ttod_pkg::STEP_W){1'b0}}, step_q};
			sub_d   = sec_roll ? ttod_pkg::STEP_W'(sub_sum - ttod_pkg::US_PER_SEC)
			                   : sub_sum[ttod_pkg::STEP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			micro_q <= '0;
			sub_q   <= '0;
		end else begin
			micro_q <= micro_d;
			sub_q   <= sub_d;
		end
	end

	// Time-of-day cascade
	ttod_pkg::tod_t tod;

	ttod_tod_cascade u_cascade (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (do_tick && sec_roll),
		.tod     (tod)
	);

	// Arm and check
	logic [ttod_pkg::US_W-1:0] deadline_d;
	logic                      expired_d;
	logic [ttod_pkg::US_W-1:0] remain;

	assign remain = deadline_s1 - micro_q;

	always_comb begin
		deadline_d = '0;
		expired_d  = 1'b0;
		unique case (req_type_s1)
			ttod_pkg::REQ_ARM:   deadline_d = micro_q + delay_us_s1;
			ttod_pkg::REQ_CHECK: expired_d  = remain[ttod_pkg::SIGN_BIT];
			default: ;
		endcase
	end

	// Result register
	logic [ttod_pkg::US_W-1:0] now_s2;
	ttod_pkg::tod_t            tod_s2;
	logic [ttod_pkg::US_W-1:0] deadline_s2;
	logic                      expired_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			now_s2      <= micro_d;
			tod_s2      <= tod;
			deadline_s2 <= deadline_d;
			expired_s2  <= expired_d;
		end
	end

	assign rsp.valid        = rsp_valid_s2;
	assign rsp.now_us       = now_s2;
	assign rsp.day_count    = tod_s2.days;
	assign rsp.hour_count   = tod_s2.hours;
	assign rsp.minute_count = tod_s2.mins;
	assign rsp.second_count = tod_s2.secs;
	assign rsp.deadline_out = deadline_s2;
	assign rsp.expired      = expired_s2;

endmodule
